[rtl/fmas_pkg.sv]
`timescale 1ns / 1ps
package fmas_pkg;
    localparam int unsigned WordW   = 32;
    localparam int unsigned MantW   = 24;
    localparam int unsigned WinW    = 64;
    localparam int unsigned CPos    = 39;
    localparam int unsigned ProdBias = 111;
    localparam int unsigned ExpMax  = 254;

    typedef struct packed {
        logic [WordW-1:0] operand_a;
        logic [WordW-1:0] operand_b;
        logic [WordW-1:0] operand_c;
    } fmas_in_t;

    typedef struct packed {
        logic [WordW-1:0] sum_result;
        logic             underflow;
    } fmas_out_t;

    // aligned sum and its side info between the two stages
    typedef struct packed {
        logic [WinW-1:0] sum;
        logic signed [10:0] exp;
        logic            sign;
    } fmas_mid_t;
endpackage

[rtl/fmas_if.sv]
`timescale 1ns / 1ps
interface fmas_in_if import fmas_pkg::*; ();
    logic     valid;
    logic     ready;
    fmas_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fmas_out_if import fmas_pkg::*; ();
    logic      valid;
    logic      ready;
    fmas_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/fmas_align.sv]
`timescale 1ns / 1ps
module fmas_align
    import fmas_pkg::*;
(
    input  fmas_in_t  in_word,
    output fmas_mid_t mid
);
    logic                sa, sb, sc, sub, c_wins;
    logic [7:0]          ea, eb, ec;
    logic [MantW-1:0]    ma, mb, mc;
    logic signed [10:0]  eab, d;
    logic [10:0]         cs, ps;
    logic [2*MantW-1:0]  prod_full;
    logic [WinW-1:0]     cal, pal, prod;

    always_comb
    begin
        sa = in_word.operand_a[31];
        sb = in_word.operand_b[31];
        sc = in_word.operand_c[31];
        ea = in_word.operand_a[30:23];
        eb = in_word.operand_b[30:23];
        ec = in_word.operand_c[30:23];
        ma = {1'b1, in_word.operand_a[22:0]};
        mb = {1'b1, in_word.operand_b[22:0]};
        mc = {1'b1, in_word.operand_c[22:0]};
        sub = sa ^ sb ^ sc;
        eab = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd111;
        d = eab - $signed({3'b000, ec});
        cs = d[10] ? 11'd0 : d;
        ps = d[10] ? 11'(-d) : 11'd0;
        prod_full = ma * mb;
        prod = {16'd0, prod_full};
        cal = (cs >= 11'd64) ? '0 : ({mc, 40'd0} >> 1) >> cs[5:0];
        pal = (ps >= 11'd64) ? '0 : prod >> ps[5:0];
        c_wins = 1'b0;
        if (sub)
        begin
            if (pal >= cal)
                mid.sum = pal - cal;
            else
            begin
                mid.sum = cal - pal;
                c_wins = 1'b1;
            end
        end
        else
            mid.sum = pal + cal;
        mid.exp = ($signed({3'b000, ec}) > eab) ? $signed({3'b000, ec}) : eab;
        mid.sign = c_wins ? sc : (sa ^ sb);
    end
endmodule

[rtl/fmas_norm.sv]
`timescale 1ns / 1ps
module fmas_norm
    import fmas_pkg::*;
(
    input  fmas_mid_t mid,
    output fmas_out_t res
);
    logic [6:0]         n;
    logic [WinW-1:0]    sh;
    logic [22:0]        frac;
    logic signed [11:0] e;

    always_comb
    begin
        n = 7'd62;
        for (int i = 0; i <= 62; i++)
        begin
            if (mid.sum[i])
                n = 7'(62 - i);
        end
        sh = mid.sum << n[5:0];
        if (mid.sum[63])
        begin
            frac = mid.sum[62:40];
            e = 12'(mid.exp) + 12'sd1;
        end
        else
        begin
            frac = sh[61:39];
            e = 12'(mid.exp) - $signed({5'd0, n});
        end
        res.underflow = 1'b0;
        if (mid.sum == '0)
            res.sum_result = '0;
        else if (e < 0)
        begin
            res.sum_result = {mid.sign, 31'd0};
            res.underflow = 1'b1;
        end
        else if (e > 12'sd254)
            res.sum_result = {mid.sign, 31'h7F7FFFFF};
        else
            res.sum_result = {mid.sign, e[7:0], frac};
    end
endmodule

[rtl/fused_multiply_add_single.sv]
`timescale 1ns / 1ps
// path: an accepted input word passes in_reg, mid_reg and res_reg in turn
// throughput: one word per cycle while out_ch is not stalled, set by the
// three-register pipeline with per-stage valid bits and skid-free stall of the whole pipe
// reset: rst_n clears all valid bits asynchronously; payload is not reset
module fused_multiply_add_single
    import fmas_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    fmas_in_if.sink    in_ch,
    fmas_out_if.source out_ch
);
    logic      v1_reg, v2_reg, v3_reg, adv;
    fmas_in_t  in_reg;
    fmas_mid_t mid_c, mid_reg;
    fmas_out_t res_c, res_reg;

    assign adv = !v3_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = v3_reg;
    assign out_ch.data = res_reg;

    fmas_align u_align (.in_word(in_reg), .mid(mid_c));
    fmas_norm  u_norm  (.mid(mid_reg), .res(res_c));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg <= in_ch.data;
            mid_reg <= mid_c;
            res_reg <= res_c;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !out_ch.ready |=> v3_reg && $stable(res_reg))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v3_reg |-> in_ch.ready)
        else $error("ready low with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v1_reg)
        else $error("accepted word lost");
    a_uf: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && res_reg.underflow |-> res_reg.sum_result[30:0] == 31'd0)
        else $error("underflow without flush");
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import fmas_pkg::*;

    logic clk;
    logic rst_n;

    fmas_in_if  in_ch ();
    fmas_out_if out_ch ();

    fused_multiply_add_single uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        bit          known;
        fmas_out_t   res;
    } fma_row_t;

    fmas_out_t   pending_q[$];
    int          mismatches = 0;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    bit          hold_receiver;
    bit          timed_out;
    longint      cycle_cnt = 0;
    int          accept_idx = 0;
    fma_row_t    rows[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic fmas_out_t fma_predict(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        fmas_out_t    r;
        logic [63:0]  ma, mb, mc, cal, pal, total;
        int           ea, eb, ec, eab, d, ex, n;
        logic         subtract, c_wins, sgn;
        logic [22:0]  frac;
        ma = {40'd0, 1'b1, a[22:0]};
        mb = {40'd0, 1'b1, b[22:0]};
        mc = {40'd0, 1'b1, c[22:0]};
        ea = a[30:23];
        eb = b[30:23];
        ec = c[30:23];
        subtract = a[31] ^ b[31] ^ c[31];
        eab = ea + eb - ProdBias;
        d = eab - ec;
        cal = mc << CPos;
        pal = ma * mb;
        if (d >= 0)
            cal = (d >= 64) ? 64'd0 : cal >> d;
        else
            pal = (-d >= 64) ? 64'd0 : pal >> (-d);
        c_wins = 1'b0;
        if (subtract)
        begin
            if (pal >= cal)
                total = pal - cal;
            else
            begin
                total = cal - pal;
                c_wins = 1'b1;
            end
        end
        else
            total = pal + cal;
        ex = (ec > eab) ? ec : eab;
        sgn = c_wins ? c[31] : (a[31] ^ b[31]);
        r.underflow = 1'b0;
        if (total == 64'd0)
            r.sum_result = 32'd0;
        else
        begin
            if (total[63])
            begin
                frac = total[62:40];
                ex = ex + 1;
            end
            else
            begin
                n = 0;
                while (n < 62 && total[62-n] == 1'b0)
                    n++;
                // shift left then take bits 61..39
                frac = 23'((total << n) >> CPos);
                ex = ex - n;
            end
            if (ex < 0)
            begin
                r.sum_result = {sgn, 31'd0};
                r.underflow = 1'b1;
            end
            else if (ex > ExpMax)
                r.sum_result = {sgn, 31'h7F7FFFFF};
            else
                r.sum_result = {sgn, ex[7:0], frac};
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom;
        // mostly keep exponents near each other so the sum path matters
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: w[30:23] = 8'($urandom_range(100, 150));
            5, 6: w[30:23] = 8'($urandom_range(40, 90));
            default: ;
        endcase
        return w;
    endfunction

    function automatic void add_row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    bit known, logic [31:0] res, logic uf);
        fma_row_t row;
        row.a = a;
        row.b = b;
        row.c = c;
        row.known = known;
        row.res.sum_result = res;
        row.res.underflow = uf;
        rows.push_back(row);
    endfunction

    task automatic send_word(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= '{operand_a: a, operand_b: b, operand_c: c};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // queue the expectation when the word is actually accepted
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            if (accept_idx < rows.size() && rows[accept_idx].known)
                pending_q.push_back(rows[accept_idx].res);
            else
                pending_q.push_back(fma_predict(in_ch.data.operand_a, in_ch.data.operand_b,
                                                in_ch.data.operand_c));
            accept_idx++;
        end
    end

    always @(posedge clk)
    begin
        fmas_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h uf=%b", out_ch.data.sum_result,
                             out_ch.data.underflow);
            end
            else
            begin
                want = pending_q.pop_front();
                if (want.sum_result !== out_ch.data.sum_result ||
                    want.underflow !== out_ch.data.underflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h uf=%b, got %h uf=%b",
                                 want.sum_result, want.underflow,
                                 out_ch.data.sum_result, out_ch.data.underflow);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_receiver)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 200000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int k;
        hold_receiver = 1'b0;
        wait (rst_n);
        @(posedge clk);
        #1;
        // long receiver hold-off while the sender keeps offering words
        hold_receiver = 1'b1;
        for (k = 0; k < 60; k++)
            @(posedge clk);
        hold_receiver = 1'b0;
    end

    initial
    begin
        int i;
        int phase;
        logic [31:0] a, b, c;
        fma_row_t row;
        sender_idle_pct = 16;
        receiver_idle_pct = 77;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // 1.0 * 1.0 + 1.0
        add_row(32'h3F800000, 32'h3F800000, 32'h3F800000, 1'b1, 32'h40000000, 1'b0);
        add_row(32'h3F800000, 32'h3F800000, 32'hBF800000, 1'b1, 32'h00000000, 1'b0);
        add_row(32'h7F7FFFFF, 32'h7F7FFFFF, 32'h3F800000, 1'b1, 32'h7F7FFFFF, 1'b0);
        add_row(32'hFF7FFFFF, 32'h7F7FFFFF, 32'h3F800000, 1'b1, 32'hFF7FFFFF, 1'b0);
        add_row(32'h00000000, 32'h00000000, 32'h80000000, 1'b1, 32'h80000000, 1'b0);
        add_row(32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 32'd0, 1'b0);
        add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0);
        add_row(32'h7F800000, 32'h7F800000, 32'h7F800000, 1'b0, 32'd0, 1'b0);
        add_row(32'h3F800000, 32'h3F800000, 32'h00000000, 1'b0, 32'd0, 1'b0);
        add_row(32'h00000000, 32'h00000000, 32'h3F800000, 1'b0, 32'd0, 1'b0);
        add_row(32'h3FFFFFFF, 32'h3FFFFFFF, 32'h40FFFFFF, 1'b0, 32'd0, 1'b0);
        add_row(32'h3FFFFFFF, 32'hBFFFFFFF, 32'h40FFFFFF, 1'b0, 32'd0, 1'b0);
        add_row(32'h3F800001, 32'h3F800000, 32'hBF800000, 1'b0, 32'd0, 1'b0);
        add_row(32'h3F800000, 32'h3F800000, 32'hBF7FFFFF, 1'b0, 32'd0, 1'b0);
        add_row(32'h3FC00000, 32'h3FC00000, 32'hC0100000, 1'b0, 32'd0, 1'b0);
        add_row(32'h00800000, 32'h00800000, 32'h80800000, 1'b0, 32'd0, 1'b0);
        add_row(32'h38000000, 32'h38000000, 32'h00000000, 1'b0, 32'd0, 1'b0);
        add_row(32'h37800000, 32'h38000000, 32'h80000000, 1'b0, 32'd0, 1'b0);
        add_row(32'h55555555, 32'hAAAAAAAA, 32'h2AAAAAAA, 1'b0, 32'd0, 1'b0);
        add_row(32'h40000000, 32'h40000000, 32'hC0800000, 1'b0, 32'd0, 1'b0);
        for (i = 0; i < rows.size(); i++)
        begin
            row = rows[i];
            send_word(row.a, row.b, row.c);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                sender_idle_pct = 77;
                receiver_idle_pct = 16;
            end
            else if (phase == 2)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            for (i = 0; i < 377; i++)
            begin
                a = rand_word();
                b = rand_word();
                c = rand_word();
                // steer some addends to cancel the product
                if ($urandom_range(0, 4) == 0)
                begin
                    c[30:23] = 8'(a[30:23] + b[30:23] - 127);
                    c[31] = ~(a[31] ^ b[31]);
                    if ($urandom_range(0, 1) == 1)
                        c[22:0] = a[22:0];
                end
                send_word(a, b, c);
                if (i == 200)
                begin
                    // pause until every expected word has come back
                    in_ch.valid <= 1'b0;
                    @(posedge clk);
                    while (pending_q.size() != 0)
                        @(posedge clk);
                end
            end
        end
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[fused_multiply_add_single.f]
rtl/fmas_pkg.sv
rtl/fmas_if.sv
rtl/fmas_align.sv
rtl/fmas_norm.sv
rtl/fused_multiply_add_single.sv
tb/tb.sv
